// ----- rtl/dba_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the disk block allocator modules
package dba_pkg;

	localparam int IDX_W    = 6;
	localparam int STATUS_W = 3;
	localparam int REQ_W    = 7;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_REQUEST = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_VICTIM,
		SRC_POS
	} idx_src_t;

	typedef struct packed {
		logic                clr;
		logic                accept;
		logic                start_scan;
		logic                start_free;
		logic                scan_adv;
		logic                mem_we;
		logic                mem_wd;
		logic                count_inc;
		logic                count_dec;
		logic                rem_dec;
		logic                emit;
		logic [STATUS_W-1:0] emit_status;
		idx_src_t            emit_src;
		logic                emit_last;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_free;
		logic want_zero;
		logic no_space;
		logic victim_oob;
		logic rd_bit;
		logic rem_one;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/dba_datapath.sv -----
`timescale 1ns / 1ps
// allocator datapath: block map memory, scan pointer, counters and output register
module dba_datapath #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dba_pkg::cmd_t                  cmd,
	output dba_pkg::sts_t                  sts,
	input  logic                           opcode,
	input  logic [dba_pkg::REQ_W-1:0]      request_count,
	input  logic [dba_pkg::IDX_W-1:0]      block_to_free,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dba_pkg::IDX_W-1:0]      block_index,
	output logic [dba_pkg::STATUS_W-1:0]   status,
	output logic                           last
);
	import dba_pkg::*;

	localparam int AW   = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW   = $clog2(NUM_BLOCKS + 1);
	localparam int CMPW = (CW > REQ_W) ? CW : REQ_W;
	localparam int VW   = (CW > IDX_W) ? CW : IDX_W;

	logic                mem_q [NUM_BLOCKS];
	logic                rd_q;
	logic [AW-1:0]       ra;
	logic [AW-1:0]       wa;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       next_pos;
	logic [AW-1:0]       start_pos;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       count_q;
	logic [REQ_W-1:0]    rem_q;
	logic [IDX_W-1:0]    victim_q;
	logic [CMPW-1:0]     free_w;
	logic [VW-1:0]       victim_w;
	logic [VW-1:0]       pos_w;
	logic                out_valid_q;
	logic [IDX_W-1:0]    idx_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;
	logic [IDX_W-1:0]    emit_idx;
	logic                out_free;

	assign next_pos  = (pos_q == AW'(NUM_BLOCKS - 1)) ? '0 : pos_q + AW'(1);
	assign start_pos = (count_q == CW'(NUM_BLOCKS)) ? '0 : count_q[AW-1:0];
	assign free_w    = CMPW'(NUM_BLOCKS) - CMPW'(count_q);
	assign victim_w  = VW'(block_to_free);
	assign pos_w     = VW'(pos_q);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		priority if (cmd.start_scan) begin
			ra = start_pos;
		end else if (cmd.start_free) begin
			ra = victim_w[AW-1:0];
		end else if (cmd.scan_adv) begin
			ra = next_pos;
		end else begin
			ra = pos_q;
		end
	end

	assign wa = cmd.clr ? clr_q : pos_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[wa] <= cmd.mem_wd;
		end
		rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk) begin
		pos_q <= ra;
		if (cmd.accept) begin
			victim_q <= block_to_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= (clr_q == AW'(NUM_BLOCKS - 1)) ? '0 : clr_q + AW'(1);
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.start_scan) begin
				rem_q <= request_count;
			end else if (cmd.rem_dec) begin
				rem_q <= rem_q - REQ_W'(1);
			end
		end
	end

	always_comb begin
		unique case (cmd.emit_src)
			SRC_VICTIM: emit_idx = victim_q;
			SRC_POS:    emit_idx = pos_w[IDX_W-1:0];
			default:    emit_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			idx_q    <= emit_idx;
			status_q <= cmd.emit_status;
			last_q   <= cmd.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign block_index = idx_q;
	assign status      = status_q;
	assign last        = last_q;

	assign sts.clr_done   = (clr_q == AW'(NUM_BLOCKS - 1));
	assign sts.is_free    = (opcode == OP_FREE);
	assign sts.want_zero  = (request_count == '0);
	assign sts.no_space   = (CMPW'(request_count) > free_w);
	assign sts.victim_oob = (victim_w >= VW'(NUM_BLOCKS));
	assign sts.rd_bit     = rd_q;
	assign sts.rem_one    = (rem_q == REQ_W'(1));
	assign sts.out_free   = out_free;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_BLOCKS))
		else $error("occupied count above map size");

	a_claim_free_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !rd_q)
		else $error("claimed a block that is occupied");

	a_claim_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> rem_q != '0)
		else $error("claimed more blocks than requested");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten before transfer");

endmodule

// ----- rtl/dba_ctrl.sv -----
`timescale 1ns / 1ps
// allocator controller: clearing pass, request decode, scan and response sequencing
module dba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dba_pkg::sts_t sts,
	output dba_pkg::cmd_t cmd
);
	import dba_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RESP  = 3'd2;
	localparam logic [2:0] S_FREE  = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [STATUS_W-1:0] resp_q;
	logic [STATUS_W-1:0] resp_d;
	idx_src_t            src_q;
	idx_src_t            src_d;
	logic                accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.emit_src = SRC_ZERO;
		state_d     = state_q;
		resp_d      = resp_q;
		src_d       = src_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr    = 1'b1;
				cmd.mem_we = 1'b1;
				cmd.mem_wd = 1'b0;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					priority if (sts.is_free && sts.victim_oob) begin
						resp_d  = ST_ALREADY_FREE;
						src_d   = SRC_VICTIM;
						state_d = S_RESP;
					end else if (sts.is_free) begin
						cmd.start_free = 1'b1;
						state_d        = S_FREE;
					end else if (sts.want_zero) begin
						resp_d  = ST_ZERO_REQUEST;
						src_d   = SRC_ZERO;
						state_d = S_RESP;
					end else if (sts.no_space) begin
						resp_d  = ST_NO_SPACE;
						src_d   = SRC_ZERO;
						state_d = S_RESP;
					end else begin
						cmd.start_scan = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = resp_q;
					cmd.emit_src    = src_q;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_FREE: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = sts.rd_bit ? ST_FREED : ST_ALREADY_FREE;
					cmd.emit_src    = SRC_VICTIM;
					cmd.emit_last   = 1'b1;
					cmd.mem_we      = sts.rd_bit;
					cmd.mem_wd      = 1'b0;
					cmd.count_dec   = sts.rd_bit;
					state_d         = S_IDLE;
				end
			end
			S_SCAN: begin
				priority if (sts.rd_bit) begin
					cmd.scan_adv = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_ALLOCATED;
					cmd.emit_src    = SRC_POS;
					cmd.emit_last   = sts.rem_one;
					cmd.mem_we      = 1'b1;
					cmd.mem_wd      = 1'b1;
					cmd.count_inc   = 1'b1;
					cmd.rem_dec     = 1'b1;
					if (sts.rem_one) begin
						state_d = S_IDLE;
					end else begin
						cmd.scan_adv = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			resp_q  <= ST_ALLOCATED;
			src_q   <= SRC_ZERO;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
			src_q   <= src_d;
		end
	end

endmodule

// ----- rtl/disk_block_allocator.sv -----
`timescale 1ns / 1ps
// Disk block allocator: bitmap of free and occupied blocks with a circular scan.
// The input channel (in_valid/in_stall) carries one request per transfer: an
// allocate of request_count blocks or a free of block_to_free. The output
// channel (out_valid/out_stall) returns one result per transfer; last marks
// the final result of a request. One request is worked at a time.
// Timing: a new request is taken at the edge after the last result of the
// previous one is loaded. Free, zero and no-space requests give a single
// result, loaded into the output register from the S_FREE or S_RESP state.
// An allocation reads the map one block per cycle through the map read port,
// starting at the block numbered by the occupied count, so N blocks visit
// between N and NUM_BLOCKS map entries; the scan pauses on a free block while
// a stalled result holds the output register. The map read port sets this rate.
// Reset: after arst_n is released a clearing pass writes every map entry to
// free, during which in_stall stays high.
// Stall: the result sits in an output register; while a loaded result is
// stalled the scan pauses at the next free block and no result is lost or
// repeated.
module disk_block_allocator #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [dba_pkg::REQ_W-1:0]    request_count,
	input  logic [dba_pkg::IDX_W-1:0]    block_to_free,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dba_pkg::IDX_W-1:0]    block_index,
	output logic [dba_pkg::STATUS_W-1:0] status,
	output logic                         last
);
	import dba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.request_count (request_count),
		.block_to_free (block_to_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_index   (block_index),
		.status        (status),
		.last          (last)
	);

endmodule

// ----- dv/dba_checker.sv -----
`timescale 1ns / 1ps
// checker for the disk block allocator: predicts block results and compares each transfer
module dba_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         opcode,
	input  logic [dba_pkg::REQ_W-1:0]    request_count,
	input  logic [dba_pkg::IDX_W-1:0]    block_to_free,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [dba_pkg::IDX_W-1:0]    block_index,
	input  logic [dba_pkg::STATUS_W-1:0] status,
	input  logic                         last,
	output int                           pending,
	output int                           failures
);
	import dba_pkg::*;

	localparam int NUM_BLOCKS = 64;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [STATUS_W-1:0] st;
		logic                lst;
	} block_result_t;

	logic [NUM_BLOCKS-1:0] occupied;
	int unsigned           used_count;
	block_result_t         expected_results[$];

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		failures++;
	endtask

	function automatic void predict_request(input logic op, input logic [REQ_W-1:0] want,
			input logic [IDX_W-1:0] victim);
		int unsigned   pos;
		int unsigned   got;
		int unsigned   steps;
		int unsigned   avail;
		block_result_t r;
		r.idx = '0;
		r.lst = 1'b1;
		if (op == OP_FREE) begin
			r.idx = victim;
			if (occupied[victim]) begin
				occupied[victim] = 1'b0;
				if (used_count > 0)
					used_count--;
				r.st = ST_FREED;
			end else begin
				r.st = ST_ALREADY_FREE;
			end
			expected_results.push_back(r);
		end else if (want == '0) begin
			r.st = ST_ZERO_REQUEST;
			expected_results.push_back(r);
		end else begin
			avail = (used_count < NUM_BLOCKS) ? NUM_BLOCKS - used_count : 0;
			if (want > avail) begin
				r.st = ST_NO_SPACE;
				expected_results.push_back(r);
			end else begin
				pos = used_count % NUM_BLOCKS;
				got = 0;
				steps = 0;
				while (got < want && steps < NUM_BLOCKS) begin
					if (!occupied[pos]) begin
						occupied[pos] = 1'b1;
						r.idx = pos[IDX_W-1:0];
						r.st = ST_ALLOCATED;
						r.lst = (got + 1 == want);
						expected_results.push_back(r);
						got++;
					end
					pos = (pos + 1) % NUM_BLOCKS;
					steps++;
				end
				used_count += got;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		block_result_t exp_r;
		if (!arst_n) begin
			occupied = '0;
			used_count = 0;
			expected_results.delete();
		end else begin
			if (in_valid && !in_stall)
				predict_request(opcode, request_count, block_to_free);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result block %0d status %0d last %0d",
						block_index, status, last));
				end else begin
					exp_r = expected_results.pop_front();
					if (block_index !== exp_r.idx)
						report_mismatch($sformatf("block_index %0d, expected %0d",
							block_index, exp_r.idx));
					if (status !== exp_r.st)
						report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.st));
					if (last !== exp_r.lst)
						report_mismatch($sformatf("last %0d, expected %0d", last, exp_r.lst));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench top for the disk block allocator: clock, reset, requests, result stalls and verdict
module testbench;
	import dba_pkg::*;

	localparam int NUM_BLOCKS  = 64;
	localparam int HOLD_CYCLES = 400;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic [REQ_W-1:0]    request_count;
	logic [IDX_W-1:0]    block_to_free;
	logic                out_valid;
	logic                out_stall;
	logic [IDX_W-1:0]    block_index;
	logic [STATUS_W-1:0] status;
	logic                last;
	int                  pending;
	int                  failures;
	bit                  no_idle;
	bit                  hold_request;

	always #2 clk = ~clk;

	disk_block_allocator u_dut (.*);

	dba_checker u_checker (.*);

	function automatic int idle_length();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic send_request(input logic op, input int cnt, input int blk);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_count <= REQ_W'(cnt);
		block_to_free <= IDX_W'(blk);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_request(input int alloc_pct);
		int roll;
		int n;
		roll = $urandom_range(99);
		if (roll < 8)
			n = 0;
		else if (roll < 78)
			n = $urandom_range(4, 1);
		else if (roll < 93)
			n = $urandom_range(16, 5);
		else
			n = $urandom_range(NUM_BLOCKS, 17);
		if ($urandom_range(99) < alloc_pct)
			send_request(OP_ALLOC, n, $urandom_range(NUM_BLOCKS - 1));
		else
			send_request(OP_FREE, n, $urandom_range(NUM_BLOCKS - 1));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side stall pattern, with a long hold when asked
	initial begin
		int busy_left;
		int open_left;
		busy_left = 0;
		open_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				busy_left = HOLD_CYCLES;
				open_left = 0;
			end
			if (busy_left == 0 && open_left == 0) begin
				busy_left = idle_length();
				open_left = $urandom_range(8, 1);
			end
			if (busy_left > 0) begin
				out_stall <= 1'b1;
				busy_left--;
			end else begin
				out_stall <= 1'b0;
				open_left--;
			end
		end
	end

	initial begin
		int order[NUM_BLOCKS];
		int j;
		int t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		request_count = '0;
		block_to_free = '0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_request(OP_ALLOC, 0, 63);
		send_request(OP_FREE, 127, 0);
		send_request(OP_FREE, 0, 63);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_ALLOC, 3, 42);
		send_request(OP_FREE, 64, 2);
		send_request(OP_ALLOC, 2, 21);
		send_request(OP_ALLOC, 64, 63);
		// wraps past the top block into the hole left at block 2
		send_request(OP_ALLOC, 59, 0);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_FREE, 0, 63);
		send_request(OP_FREE, 0, 0);
		send_request(OP_ALLOC, 2, 63);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_FREE, 0, 21);
		send_request(OP_FREE, 0, 42);

		repeat (100) random_request(40);

		// long result hold while requests keep coming
		hold_request = 1'b1;
		no_idle = 1'b1;
		repeat (6) random_request(60);
		no_idle = 1'b0;
		wait_drained();

		no_idle = 1'b1;
		repeat (60) random_request(45);
		no_idle = 1'b0;

		// empty the map in random order, then take all of it at once
		for (int i = 0; i < NUM_BLOCKS; i++)
			order[i] = i;
		for (int i = NUM_BLOCKS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < NUM_BLOCKS; i++)
			send_request(OP_FREE, $urandom_range(NUM_BLOCKS), order[i]);
		send_request(OP_ALLOC, NUM_BLOCKS, $urandom_range(NUM_BLOCKS - 1));

		repeat (40) random_request(35);
		in_valid <= 1'b0;

		wait_drained();
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dba_pkg.sv
rtl/dba_datapath.sv
rtl/dba_ctrl.sv
rtl/disk_block_allocator.sv
dv/dba_checker.sv
dv/testbench.sv
